// ----- design/nested_length_prefixed_parser_unit_assert.svh -----
// Assertion macros used by the parser step module nlpp_parse.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef NESTED_LENGTH_PREFIXED_PARSER_UNIT_ASSERT_SVH
`define NESTED_LENGTH_PREFIXED_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NLPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NLPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/nlpp_pkg.sv -----
// Shared types and constants of the nested length-prefixed parser.
// No dependencies; used by nlpp_parse, nlpp_res_fifo and the top level.
package nlpp_pkg;

  typedef enum logic [1:0] {
    KindBlockOpen = 2'd0,
    KindPayload   = 2'd1,
    KindEmptyItem = 2'd2,
    KindStatus    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusMissing   = 2'd1,
    StatusTruncated = 2'd2,
    StatusOverflow  = 2'd3
  } status_e;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam int unsigned Radix    = 10;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] block_index;
    logic [15:0] item_index;
    logic [15:0] item_count;
    logic        first_of_item;
    logic        last_of_item;
    status_e     status;
    logic        last_result;
  } res_t;

  // Up to two results produced by one input item.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- design/nlpp_parse.sv -----
// Parser state and single-pass step logic: one buffered item in, up to two results out.
// Depends on nlpp_pkg and the assertion macro header.
`include "nested_length_prefixed_parser_unit_assert.svh"

module nlpp_parse #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               byte_valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               eos_i,
  output nlpp_pkg::push_t    push_o
);

  localparam int unsigned AccW = COUNT_WIDTH + 4;

  typedef enum logic [2:0] {
    PhBlocks  = 3'd0,
    PhItems   = 3'd1,
    PhLen     = 3'd2,
    PhPayload = 3'd3,
    PhDone    = 3'd4
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]  acc_q, acc_d;
  logic                    in_digits_q, in_digits_d;
  logic [COUNT_WIDTH-1:0]  blk_rem_q, blk_rem_d;
  logic [COUNT_WIDTH-1:0]  item_rem_q, item_rem_d;
  logic [COUNT_WIDTH-1:0]  pay_rem_q, pay_rem_d;
  logic [COUNT_WIDTH-1:0]  cur_blk_q, cur_blk_d;
  logic [COUNT_WIDTH-1:0]  cur_item_q, cur_item_d;
  logic                    saw_q, saw_d;
  nlpp_pkg::status_e       sticky_q, sticky_d;
  logic                    started_q, started_d;

  nlpp_pkg::res_t          res [2];
  logic [1:0]              n_res;

  always_comb begin
    logic [AccW-1:0]         nv;
    logic [COUNT_WIDTH-1:0]  v;
    logic                    complete;
    logic                    has_term;
    logic                    do_pay;
    logic                    fin_item;
    logic                    fin_blk;
    logic                    is_last;
    nlpp_pkg::res_t          r;

    phase_d     = phase_q;
    acc_d       = acc_q;
    in_digits_d = in_digits_q;
    blk_rem_d   = blk_rem_q;
    item_rem_d  = item_rem_q;
    pay_rem_d   = pay_rem_q;
    cur_blk_d   = cur_blk_q;
    cur_item_d  = cur_item_q;
    saw_d       = saw_q;
    sticky_d    = sticky_q;
    started_d   = started_q;
    res[0]      = '0;
    res[1]      = '0;
    n_res       = 2'd0;
    complete    = 1'b0;
    has_term    = 1'b0;
    do_pay      = 1'b0;
    fin_item    = 1'b0;
    fin_blk     = 1'b0;
    is_last     = 1'b0;
    r           = '0;
    v           = '0;
    nv          = '0;

    // Byte step: digit accumulate, number end, or payload byte.
    if (byte_valid_i) begin
      saw_d = 1'b1;
      if (phase_q == PhPayload) begin
        do_pay = 1'b1;
      end else if (phase_q != PhDone) begin
        if (data_byte_i inside {[nlpp_pkg::CharZero:nlpp_pkg::CharNine]}) begin
          nv = AccW'(acc_q) * AccW'(nlpp_pkg::Radix)
             + AccW'(4'(data_byte_i - nlpp_pkg::CharZero));
          if (nv[AccW-1:COUNT_WIDTH] != 4'd0) begin
            acc_d = '1;
            if (sticky_q == nlpp_pkg::StatusOk) begin
              sticky_d = nlpp_pkg::StatusOverflow;
            end
          end else begin
            acc_d = nv[COUNT_WIDTH-1:0];
          end
          in_digits_d = 1'b1;
        end else if (in_digits_q) begin
          complete = 1'b1;
          has_term = (data_byte_i != nlpp_pkg::CharSpace);
        end
      end
    end

    // A number still open at end of stream completes first; a number already
    // closed by this byte keeps its terminator.
    if (eos_i && !complete && in_digits_d &&
        (phase_d == PhBlocks || phase_d == PhItems || phase_d == PhLen)) begin
      complete = 1'b1;
      has_term = 1'b0;
    end

    if (complete) begin
      v           = acc_d;
      acc_d       = '0;
      in_digits_d = 1'b0;
      case (phase_d)
        PhBlocks: begin
          blk_rem_d = v;
          cur_blk_d = '0;
          phase_d   = (v == '0) ? PhDone : PhItems;
        end
        PhItems: begin
          r             = '0;
          r.kind        = nlpp_pkg::KindBlockOpen;
          r.block_index = 16'(cur_blk_d);
          r.item_count  = 16'(v);
          res[n_res[0]] = r;
          n_res         = n_res + 2'd1;
          item_rem_d    = v;
          cur_item_d    = '0;
          if (v == '0) begin
            fin_blk = 1'b1;
          end else begin
            phase_d = PhLen;
          end
        end
        PhLen: begin
          if (v == '0) begin
            r             = '0;
            r.kind        = nlpp_pkg::KindEmptyItem;
            r.block_index = 16'(cur_blk_d);
            r.item_index  = 16'(cur_item_d);
            res[n_res[0]] = r;
            n_res         = n_res + 2'd1;
            fin_item      = 1'b1;
          end else begin
            pay_rem_d = v;
            started_d = 1'b0;
            phase_d   = PhPayload;
            do_pay    = has_term;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_pay) begin
      r               = '0;
      r.kind          = nlpp_pkg::KindPayload;
      r.payload_byte  = data_byte_i;
      r.block_index   = 16'(cur_blk_d);
      r.item_index    = 16'(cur_item_d);
      r.first_of_item = !started_d;
      started_d       = 1'b1;
      pay_rem_d       = pay_rem_d - COUNT_WIDTH'(1);
      is_last         = (pay_rem_d == '0);
      r.last_of_item  = is_last;
      res[n_res[0]]   = r;
      n_res           = n_res + 2'd1;
      fin_item        = is_last;
    end

    // Advance item and block counters.
    if (fin_item) begin
      cur_item_d = cur_item_d + COUNT_WIDTH'(1);
      item_rem_d = item_rem_d - COUNT_WIDTH'(1);
      if (item_rem_d == '0) begin
        fin_blk = 1'b1;
      end else begin
        phase_d = PhLen;
      end
    end
    if (fin_blk) begin
      cur_blk_d = cur_blk_d + COUNT_WIDTH'(1);
      blk_rem_d = blk_rem_d - COUNT_WIDTH'(1);
      phase_d   = (blk_rem_d == '0) ? PhDone : PhItems;
    end

    // End of stream: report status and return to the reset state.
    if (eos_i) begin
      r      = '0;
      r.kind = nlpp_pkg::KindStatus;
      if (sticky_d != nlpp_pkg::StatusOk) begin
        r.status = sticky_d;
      end else if (!saw_d || phase_d == PhDone) begin
        r.status = nlpp_pkg::StatusOk;
      end else if (phase_d == PhPayload) begin
        r.status = nlpp_pkg::StatusTruncated;
      end else begin
        r.status = nlpp_pkg::StatusMissing;
      end
      res[n_res[0]] = r;
      n_res         = n_res + 2'd1;
      phase_d       = PhBlocks;
      acc_d         = '0;
      in_digits_d   = 1'b0;
      blk_rem_d     = '0;
      item_rem_d    = '0;
      pay_rem_d     = '0;
      cur_blk_d     = '0;
      cur_item_d    = '0;
      saw_d         = 1'b0;
      sticky_d      = nlpp_pkg::StatusOk;
      started_d     = 1'b0;
    end

    // Tag the last result of this item.
    if (n_res == 2'd2) begin
      res[1].last_result = 1'b1;
    end else if (n_res == 2'd1) begin
      res[0].last_result = 1'b1;
    end
  end

  assign push_o.cnt = n_res;
  assign push_o.r0  = res[0];
  assign push_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhBlocks;
      acc_q       <= '0;
      in_digits_q <= 1'b0;
      blk_rem_q   <= '0;
      item_rem_q  <= '0;
      pay_rem_q   <= '0;
      cur_blk_q   <= '0;
      cur_item_q  <= '0;
      saw_q       <= 1'b0;
      sticky_q    <= nlpp_pkg::StatusOk;
      started_q   <= 1'b0;
    end else if (adv_i) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      in_digits_q <= in_digits_d;
      blk_rem_q   <= blk_rem_d;
      item_rem_q  <= item_rem_d;
      pay_rem_q   <= pay_rem_d;
      cur_blk_q   <= cur_blk_d;
      cur_item_q  <= cur_item_d;
      saw_q       <= saw_d;
      sticky_q    <= sticky_d;
      started_q   <= started_d;
    end
  end

  `NLPP_ASSERT_NOW(a_eos_has_result, eos_i, n_res != 2'd0, "end of stream without status")
  `NLPP_ASSERT_NOW(a_two_only_at_eos, n_res == 2'd2, eos_i, "two results without end")
  `NLPP_ASSERT_NOW(a_payload_left, phase_q == PhPayload, pay_rem_q != '0, "no payload left")
  `NLPP_ASSERT_NOW(a_digits_phase, in_digits_q, phase_q <= PhLen, "open number in wrong phase")
  `NLPP_ASSERT_NEXT(a_eos_resets, adv_i && eos_i, phase_q == PhBlocks && !saw_q, "no clear at end")

endmodule

// ----- design/nlpp_res_fifo.sv -----
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on nlpp_pkg.
module nlpp_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_en_i,
  input  nlpp_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output nlpp_pkg::res_t    head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  nlpp_pkg::res_t    mem [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        n_push;
  logic              do_pop;

  assign n_push = push_en_i ? push_i.cnt : 2'd0;
  assign do_pop = pop_i && valid_o;
  assign wr_d   = wr_q + PtrW'(n_push);
  assign rd_d   = rd_q + PtrW'(do_pop);
  assign cnt_d  = cnt_q + CntW'(n_push) - CntW'(do_pop);

  // Room for a worst-case item of two results.
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (n_push == 2'd2) begin
      mem[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/nested_length_prefixed_parser_unit.sv -----
// Top level of the nested length-prefixed record parser.
// Depends on nlpp_pkg, nlpp_parse and nlpp_res_fifo.
//
//  channel  | direction | carries
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one stream byte and/or end-of-stream mark per request
//  m_axis   | out       | parse events: block open, payload, empty item, status
//
// Cycles: one request is accepted per cycle while s_axis_tready is high.
// Each request waits in the input register until the queue has room; there
// the parse step updates state and pushes its results into a four-entry
// result queue, whose registered head shows on m_axis. Most requests yield
// zero or one result; an end-of-stream request whose byte or open number also
// yields an event gives two, which the output side hands out one at a time.
// Reset: rst_ni clears parser state, the input register's valid flag and the queue.
// Stalls: hold s_axis_tready low while the input register is full and the
// queue has fewer than two free entries.
module nested_length_prefixed_parser_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] block_index,
                                      // [39:24] item_index, [55:40] item_count,
                                      // [56] first_of_item, [57] last_of_item,
                                      // [59:58] status, [63:60] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_result
);

  logic             in_valid_q, in_valid_d;
  logic             in_bv_q;
  logic [7:0]       in_byte_q;
  logic             in_eos_q;
  logic             room;
  logic             adv;
  logic             s_take;
  nlpp_pkg::push_t  push;
  nlpp_pkg::res_t   head;

  // Advance the buffered request once the queue can absorb its results.
  assign adv           = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_take || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_bv_q   <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tlast;
    end
  end

  nlpp_parse #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .byte_valid_i (in_bv_q),
    .data_byte_i  (in_byte_q),
    .eos_i        (in_eos_q),
    .push_o       (push)
  );

  nlpp_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (adv),
    .push_i    (push),
    .pop_i     (m_axis_tready),
    .room_o    (room),
    .valid_o   (m_axis_tvalid),
    .head_o    (head)
  );

  assign m_axis_tdata = {4'b0000, head.status, head.last_of_item, head.first_of_item,
                         head.item_count, head.item_index, head.block_index,
                         head.payload_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_result;

endmodule
